[src/tcct_pkg.sv]
`default_nettype none

package tcct_pkg;

  // Default coordinate width and number of fraction bits of the center.
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // The center coordinates are always signed 40-bit words.
  localparam int unsigned OUT_BITS = 40;
  // One quotient bit more than the output, so that saturation can be seen.
  localparam int unsigned QUO_BITS = OUT_BITS + 1;

  // Flags that travel beside the numbers through the divider.
  typedef struct packed {
    logic deg;
    logic in_circle;
    logic is_vtx;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } side_t;

  // One finished result word.
  typedef struct packed {
    logic [OUT_BITS-1:0] cx;
    logic [OUT_BITS-1:0] cy;
    logic                in_circle;
    logic                deg;
    logic                is_vtx;
    logic                sat;
  } res_t;

endpackage

`default_nettype wire

[src/triangle_circumcircle_test_unit.sv]
`default_nettype none

// Circumcircle test unit. Each input word carries the three vertices of a
// triangle and a query point. Each output word gives the circumcenter in
// signed 40-bit fixed point with FRAC_BITS fraction bits, Q31.8 by default
// (truncated toward zero, saturated with a flag), whether the query lies
// inside or on the circumcircle, whether the triangle is degenerate, and whether the query equals a vertex.
// Both channels use valid and stall: a word moves on a rising edge where
// valid is high and stall is low. Exactly one output word follows each
// input word, in order.
// From acceptance to out_valid_o a word passes eight arithmetic stages,
// one divider stage for each of the 41 quotient bits, and the output
// register. Throughput is one word per cycle while in_stall_o is low; the
// divider sets the latency, and every stage takes a new word each cycle.
// When the receiver stalls, a finished word waits in the output register and
// the next one is caught in a skid register; only while the skid register is
// full does in_stall_o rise and the pipeline hold. Reset clears all valid
// bits, so the block comes up empty and ready.
module triangle_circumcircle_test_unit #(
  parameter int unsigned COORD_BITS = tcct_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tcct_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]        vertex_a_x_i,
  input  wire logic signed [COORD_BITS-1:0]        vertex_a_y_i,
  input  wire logic signed [COORD_BITS-1:0]        vertex_b_x_i,
  input  wire logic signed [COORD_BITS-1:0]        vertex_b_y_i,
  input  wire logic signed [COORD_BITS-1:0]        vertex_c_x_i,
  input  wire logic signed [COORD_BITS-1:0]        vertex_c_y_i,
  input  wire logic signed [COORD_BITS-1:0]        query_x_i,
  input  wire logic signed [COORD_BITS-1:0]        query_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [tcct_pkg::OUT_BITS-1:0]     center_x_o,
  output logic signed [tcct_pkg::OUT_BITS-1:0]     center_y_o,
  output logic                                     inside_res_o,
  output logic                                     degenerate_o,
  output logic                                     is_vertex_o,
  output logic                                     center_saturated_o
);

  import tcct_pkg::*;

  // Widths of the intermediate values.
  localparam int unsigned DF     = COORD_BITS + 1;  // coordinate sums and differences
  localparam int unsigned PR     = 2 * DF;          // products of two of those
  localparam int unsigned CS_W   = PR + 1;          // C1, C2, squared distances
  localparam int unsigned DET_W  = CS_W + 2;        // determinant, four times orientation
  localparam int unsigned AB_W   = DF + 1;          // A1, B1, A2, B2
  localparam int unsigned P4_W   = CS_W + AB_W;
  localparam int unsigned N_W    = P4_W + 1;        // Cramer numerators
  localparam int unsigned UP_W   = DF + CS_W;
  localparam int unsigned U_W    = UP_W + 1;
  localparam int unsigned T_W    = DF + U_W;
  localparam int unsigned T3_W   = 2 * CS_W;
  localparam int unsigned INC_W  = T_W + 2;         // incircle determinant
  localparam int unsigned NS_W   = N_W + FRAC_BITS;
  localparam int unsigned RW     = (NS_W > DET_W + QUO_BITS) ? NS_W : DET_W + QUO_BITS;

  localparam logic [QUO_BITS-1:0] POS_LIM = {2'b00, {(OUT_BITS-1){1'b1}}};
  localparam logic [QUO_BITS-1:0] NEG_LIM = {2'b01, {(OUT_BITS-1){1'b0}}};

  // Saturates a quotient magnitude and applies its sign; the top bit is the
  // saturation flag.
  function automatic logic [OUT_BITS:0] fmt_coord(input logic [QUO_BITS-1:0] q,
                                                  input logic neg, input logic ovf);
    logic [QUO_BITS-1:0] lim;
    logic [QUO_BITS-1:0] mag;
    logic [QUO_BITS-1:0] val;
    logic                sat;
    lim = neg ? NEG_LIM : POS_LIM;
    sat = ovf || (q > lim);
    mag = sat ? lim : q;
    val = neg ? (QUO_BITS'(0) - mag) : mag;
    return {sat, val[OUT_BITS-1:0]};
  endfunction

  logic adv;
  logic skid_full_q;
  logic out_valid_q;
  logic out_take;

  // The whole pipeline moves unless the skid register holds a word.
  assign adv        = ~skid_full_q;
  assign in_stall_o = skid_full_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  // Stage 1: sums and differences of the coordinates.
  logic signed [DF-1:0] s1_dabx_q, s1_sabx_q, s1_daby_q, s1_saby_q;
  logic signed [DF-1:0] s1_dacx_q, s1_sacx_q, s1_dacy_q, s1_sacy_q;
  logic signed [DF-1:0] s1_adx_q, s1_ady_q, s1_bdx_q, s1_bdy_q, s1_cdx_q, s1_cdy_q;
  logic                 s1_isv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dabx_q <= DF'(vertex_a_x_i) - DF'(vertex_b_x_i);
      s1_sabx_q <= DF'(vertex_a_x_i) + DF'(vertex_b_x_i);
      s1_daby_q <= DF'(vertex_a_y_i) - DF'(vertex_b_y_i);
      s1_saby_q <= DF'(vertex_a_y_i) + DF'(vertex_b_y_i);
      s1_dacx_q <= DF'(vertex_a_x_i) - DF'(vertex_c_x_i);
      s1_sacx_q <= DF'(vertex_a_x_i) + DF'(vertex_c_x_i);
      s1_dacy_q <= DF'(vertex_a_y_i) - DF'(vertex_c_y_i);
      s1_sacy_q <= DF'(vertex_a_y_i) + DF'(vertex_c_y_i);
      s1_adx_q  <= DF'(vertex_a_x_i) - DF'(query_x_i);
      s1_ady_q  <= DF'(vertex_a_y_i) - DF'(query_y_i);
      s1_bdx_q  <= DF'(vertex_b_x_i) - DF'(query_x_i);
      s1_bdy_q  <= DF'(vertex_b_y_i) - DF'(query_y_i);
      s1_cdx_q  <= DF'(vertex_c_x_i) - DF'(query_x_i);
      s1_cdy_q  <= DF'(vertex_c_y_i) - DF'(query_y_i);
      s1_isv_q  <= (query_x_i == vertex_a_x_i && query_y_i == vertex_a_y_i) ||
                   (query_x_i == vertex_b_x_i && query_y_i == vertex_b_y_i) ||
                   (query_x_i == vertex_c_x_i && query_y_i == vertex_c_y_i);
    end
  end

  // Stage 2: first products. The difference of squares is taken as
  // (a - b) * (a + b).
  logic signed [PR-1:0] s2_pabx_q, s2_paby_q, s2_pacx_q, s2_pacy_q, s2_dm1_q, s2_dm2_q;
  logic signed [PR-1:0] s2_sqax_q, s2_sqay_q, s2_sqbx_q, s2_sqby_q, s2_sqcx_q, s2_sqcy_q;
  logic signed [PR-1:0] s2_om1_q, s2_om2_q;
  logic signed [DF-1:0] s2_dabx_q, s2_daby_q, s2_dacx_q, s2_dacy_q;
  logic signed [DF-1:0] s2_adx_q, s2_ady_q, s2_bdx_q, s2_bdy_q, s2_cdx_q, s2_cdy_q;
  logic                 s2_isv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pabx_q <= PR'(s1_dabx_q) * PR'(s1_sabx_q);
      s2_paby_q <= PR'(s1_daby_q) * PR'(s1_saby_q);
      s2_pacx_q <= PR'(s1_dacx_q) * PR'(s1_sacx_q);
      s2_pacy_q <= PR'(s1_dacy_q) * PR'(s1_sacy_q);
      s2_dm1_q  <= PR'(s1_dabx_q) * PR'(s1_dacy_q);
      s2_dm2_q  <= PR'(s1_dacx_q) * PR'(s1_daby_q);
      s2_sqax_q <= PR'(s1_adx_q) * PR'(s1_adx_q);
      s2_sqay_q <= PR'(s1_ady_q) * PR'(s1_ady_q);
      s2_sqbx_q <= PR'(s1_bdx_q) * PR'(s1_bdx_q);
      s2_sqby_q <= PR'(s1_bdy_q) * PR'(s1_bdy_q);
      s2_sqcx_q <= PR'(s1_cdx_q) * PR'(s1_cdx_q);
      s2_sqcy_q <= PR'(s1_cdy_q) * PR'(s1_cdy_q);
      s2_om1_q  <= PR'(s1_bdx_q) * PR'(s1_cdy_q);
      s2_om2_q  <= PR'(s1_cdx_q) * PR'(s1_bdy_q);
      s2_dabx_q <= s1_dabx_q;
      s2_daby_q <= s1_daby_q;
      s2_dacx_q <= s1_dacx_q;
      s2_dacy_q <= s1_dacy_q;
      s2_adx_q  <= s1_adx_q;
      s2_ady_q  <= s1_ady_q;
      s2_bdx_q  <= s1_bdx_q;
      s2_bdy_q  <= s1_bdy_q;
      s2_cdx_q  <= s1_cdx_q;
      s2_cdy_q  <= s1_cdy_q;
      s2_isv_q  <= s1_isv_q;
    end
  end

  // Stage 3: C1, C2, the determinant, the squared distances to the query and
  // the orientation term of the incircle determinant.
  logic signed [CS_W-1:0]  s3_c1_q, s3_c2_q, s3_al_q, s3_bl_q, s3_cl_q, s3_ori_q;
  logic signed [DET_W-1:0] s3_det_q;
  logic signed [AB_W-1:0]  s3_a1_q, s3_b1_q, s3_a2_q, s3_b2_q;
  logic signed [DF-1:0]    s3_adx_q, s3_ady_q, s3_bdx_q, s3_bdy_q, s3_cdy_q, s3_cdx_q;
  logic                    s3_isv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_c1_q  <= CS_W'(s2_pabx_q) + CS_W'(s2_paby_q);
      s3_c2_q  <= CS_W'(s2_pacx_q) + CS_W'(s2_pacy_q);
      s3_det_q <= {CS_W'(s2_dm1_q) - CS_W'(s2_dm2_q), 2'b00};
      s3_al_q  <= CS_W'(s2_sqax_q) + CS_W'(s2_sqay_q);
      s3_bl_q  <= CS_W'(s2_sqbx_q) + CS_W'(s2_sqby_q);
      s3_cl_q  <= CS_W'(s2_sqcx_q) + CS_W'(s2_sqcy_q);
      s3_ori_q <= CS_W'(s2_om1_q) - CS_W'(s2_om2_q);
      s3_a1_q  <= {s2_dabx_q, 1'b0};
      s3_b1_q  <= {s2_daby_q, 1'b0};
      s3_a2_q  <= {s2_dacx_q, 1'b0};
      s3_b2_q  <= {s2_dacy_q, 1'b0};
      s3_adx_q <= s2_adx_q;
      s3_ady_q <= s2_ady_q;
      s3_bdx_q <= s2_bdx_q;
      s3_bdy_q <= s2_bdy_q;
      s3_cdx_q <= s2_cdx_q;
      s3_cdy_q <= s2_cdy_q;
      s3_isv_q <= s2_isv_q;
    end
  end

  // Stage 4: products of the Cramer numerators and the inner incircle terms.
  logic signed [P4_W-1:0]  s4_nx1_q, s4_nx2_q, s4_ny1_q, s4_ny2_q;
  logic signed [UP_W-1:0]  s4_u1_q, s4_u2_q, s4_w1_q, s4_w2_q;
  logic signed [T3_W-1:0]  s4_t3_q;
  logic signed [DET_W-1:0] s4_det_q;
  logic signed [DF-1:0]    s4_adx_q, s4_ady_q;
  logic                    s4_isv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_nx1_q <= P4_W'(s3_c1_q) * P4_W'(s3_b2_q);
      s4_nx2_q <= P4_W'(s3_c2_q) * P4_W'(s3_b1_q);
      s4_ny1_q <= P4_W'(s3_a1_q) * P4_W'(s3_c2_q);
      s4_ny2_q <= P4_W'(s3_a2_q) * P4_W'(s3_c1_q);
      s4_u1_q  <= UP_W'(s3_bdy_q) * UP_W'(s3_cl_q);
      s4_u2_q  <= UP_W'(s3_cdy_q) * UP_W'(s3_bl_q);
      s4_w1_q  <= UP_W'(s3_bdx_q) * UP_W'(s3_cl_q);
      s4_w2_q  <= UP_W'(s3_cdx_q) * UP_W'(s3_bl_q);
      s4_t3_q  <= T3_W'(s3_al_q) * T3_W'(s3_ori_q);
      s4_det_q <= s3_det_q;
      s4_adx_q <= s3_adx_q;
      s4_ady_q <= s3_ady_q;
      s4_isv_q <= s3_isv_q;
    end
  end

  // Stage 5: numerator differences and the inner incircle differences.
  logic signed [N_W-1:0]   s5_nx_q, s5_ny_q;
  logic signed [U_W-1:0]   s5_u_q, s5_w_q;
  logic signed [T3_W-1:0]  s5_t3_q;
  logic signed [DET_W-1:0] s5_det_q;
  logic signed [DF-1:0]    s5_adx_q, s5_ady_q;
  logic                    s5_isv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_nx_q  <= N_W'(s4_nx1_q) - N_W'(s4_nx2_q);
      s5_ny_q  <= N_W'(s4_ny1_q) - N_W'(s4_ny2_q);
      s5_u_q   <= U_W'(s4_u1_q) - U_W'(s4_u2_q);
      s5_w_q   <= U_W'(s4_w1_q) - U_W'(s4_w2_q);
      s5_t3_q  <= s4_t3_q;
      s5_det_q <= s4_det_q;
      s5_adx_q <= s4_adx_q;
      s5_ady_q <= s4_ady_q;
      s5_isv_q <= s4_isv_q;
    end
  end

  // Stage 6: outer incircle products.
  logic signed [T_W-1:0]   s6_t1_q, s6_t2_q;
  logic signed [T3_W-1:0]  s6_t3_q;
  logic signed [N_W-1:0]   s6_nx_q, s6_ny_q;
  logic signed [DET_W-1:0] s6_det_q;
  logic                    s6_isv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_t1_q  <= T_W'(s5_adx_q) * T_W'(s5_u_q);
      s6_t2_q  <= T_W'(s5_ady_q) * T_W'(s5_w_q);
      s6_t3_q  <= s5_t3_q;
      s6_nx_q  <= s5_nx_q;
      s6_ny_q  <= s5_ny_q;
      s6_det_q <= s5_det_q;
      s6_isv_q <= s5_isv_q;
    end
  end

  // Stage 7: the incircle sign decides the inside flag. The determinant is
  // four times the orientation, so the test flips for a clockwise triangle.
  // Magnitudes and signs prepare the unsigned division.
  logic signed [INC_W-1:0] inc;
  logic                    det_zero;
  logic                    inside_d;

  assign inc      = INC_W'(s6_t1_q) - INC_W'(s6_t2_q) + INC_W'(s6_t3_q);
  assign det_zero = (s6_det_q == '0);
  assign inside_d = ~det_zero &&
                    (s6_det_q[DET_W-1] ? (inc[INC_W-1] || inc == '0) : ~inc[INC_W-1]);

  logic [N_W-1:0]   s7_nmx_q, s7_nmy_q;
  logic [DET_W-1:0] s7_dmag_q;
  side_t            s7_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_nmx_q  <= s6_nx_q[N_W-1] ? N_W'(-s6_nx_q) : N_W'(s6_nx_q);
      s7_nmy_q  <= s6_ny_q[N_W-1] ? N_W'(-s6_ny_q) : N_W'(s6_ny_q);
      s7_dmag_q <= s6_det_q[DET_W-1] ? DET_W'(-s6_det_q) : DET_W'(s6_det_q);
      s7_side_q <= '{deg:       det_zero,
                     in_circle: inside_d,
                     is_vtx:    s6_isv_q,
                     neg_x:     s6_nx_q[N_W-1] ^ s6_det_q[DET_W-1],
                     neg_y:     s6_ny_q[N_W-1] ^ s6_det_q[DET_W-1],
                     ovf_x:     1'b0,
                     ovf_y:     1'b0};
    end
  end

  // Stage 8: scale the numerators by the fraction bits and catch quotients
  // too large for the divider's quotient width.
  logic [RW-1:0] nsx, nsy, dlim;
  logic [RW-1:0] s8_nx_q, s8_ny_q;
  logic [DET_W-1:0] s8_den_q;
  side_t         side8_d;
  side_t         s8_side_q;

  assign nsx  = RW'(s7_nmx_q) << FRAC_BITS;
  assign nsy  = RW'(s7_nmy_q) << FRAC_BITS;
  assign dlim = RW'(s7_dmag_q) << QUO_BITS;

  always_comb begin
    side8_d       = s7_side_q;
    side8_d.ovf_x = (nsx >= dlim);
    side8_d.ovf_y = (nsy >= dlim);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_nx_q   <= nsx;
      s8_ny_q   <= nsy;
      s8_den_q  <= s7_dmag_q;
      s8_side_q <= side8_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  // Divider: one quotient bit per stage for both coordinates.
  logic                div_v;
  logic [QUO_BITS-1:0] div_qx, div_qy;
  side_t               div_side;

  tcct_div #(
    .RW(RW),
    .DW(DET_W),
    .QB(QUO_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v8_q),
    .num_x_i (s8_nx_q),
    .num_y_i (s8_ny_q),
    .den_i   (s8_den_q),
    .side_i  (s8_side_q),
    .valid_o (div_v),
    .quo_x_o (div_qx),
    .quo_y_o (div_qy),
    .side_o  (div_side)
  );

  // Final formatting. A degenerate triangle reports a zero center.
  logic [OUT_BITS:0] fx, fy;
  res_t              res_d;

  assign fx = fmt_coord(div_qx, div_side.neg_x, div_side.ovf_x);
  assign fy = fmt_coord(div_qy, div_side.neg_y, div_side.ovf_y);

  always_comb begin
    res_d.cx        = div_side.deg ? '0 : fx[OUT_BITS-1:0];
    res_d.cy        = div_side.deg ? '0 : fy[OUT_BITS-1:0];
    res_d.sat       = ~div_side.deg & (fx[OUT_BITS] | fy[OUT_BITS]);
    res_d.in_circle = div_side.in_circle;
    res_d.deg       = div_side.deg;
    res_d.is_vtx    = div_side.is_vtx;
  end

  // Output register with a skid register behind it.
  res_t out_q, skid_q;

  assign out_take = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (out_take) begin
        skid_full_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= div_v;
    end else if (div_v) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_take) begin
      out_q <= res_d;
    end else begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign center_x_o         = out_q.cx;
  assign center_y_o         = out_q.cy;
  assign inside_res_o       = out_q.in_circle;
  assign degenerate_o       = out_q.deg;
  assign is_vertex_o        = out_q.is_vtx;
  assign center_saturated_o = out_q.sat;

endmodule

`default_nettype wire

[src/tcct_div.sv]
`default_nettype none

// Pipelined restoring divider for two numerators over one denominator.
// Each stage settles one quotient bit, most significant bit first.
module tcct_div #(
  parameter int unsigned RW = 80,
  parameter int unsigned DW = 36,
  parameter int unsigned QB = 41
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic            valid_i,
  input  wire logic [RW-1:0]   num_x_i,
  input  wire logic [RW-1:0]   num_y_i,
  input  wire logic [DW-1:0]   den_i,
  input  tcct_pkg::side_t      side_i,
  output logic                 valid_o,
  output logic [QB-1:0]        quo_x_o,
  output logic [QB-1:0]        quo_y_o,
  output tcct_pkg::side_t      side_o
);

  import tcct_pkg::*;

  logic [QB-1:0] v_q;
  logic [RW-1:0] rx_q [QB];
  logic [RW-1:0] ry_q [QB];
  logic [QB-1:0] qx_q [QB];
  logic [QB-1:0] qy_q [QB];
  logic [DW-1:0] d_q  [QB];
  side_t         s_q  [QB];

  logic [RW-1:0] src_rx [QB];
  logic [RW-1:0] src_ry [QB];
  logic [QB-1:0] src_qx [QB];
  logic [QB-1:0] src_qy [QB];
  logic [DW-1:0] src_d  [QB];
  side_t         src_s  [QB];
  logic [QB-1:0] src_v;

  logic [RW-1:0] rx_d [QB];
  logic [RW-1:0] ry_d [QB];
  logic [QB-1:0] qx_d [QB];
  logic [QB-1:0] qy_d [QB];

  always_comb begin
    src_rx[0] = num_x_i;
    src_ry[0] = num_y_i;
    src_qx[0] = '0;
    src_qy[0] = '0;
    src_d[0]  = den_i;
    src_s[0]  = side_i;
    src_v[0]  = valid_i;
    for (int k = 1; k < QB; k++) begin
      src_rx[k] = rx_q[k-1];
      src_ry[k] = ry_q[k-1];
      src_qx[k] = qx_q[k-1];
      src_qy[k] = qy_q[k-1];
      src_d[k]  = d_q[k-1];
      src_s[k]  = s_q[k-1];
      src_v[k]  = v_q[k-1];
    end
  end

  // Stage k trial-subtracts the denominator shifted to quotient bit QB-1-k.
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      logic [RW-1:0] dsh;
      logic [RW:0]   dfx;
      logic [RW:0]   dfy;
      dsh = RW'(src_d[k]) << (QB - 1 - k);
      dfx = {1'b0, src_rx[k]} - {1'b0, dsh};
      dfy = {1'b0, src_ry[k]} - {1'b0, dsh};
      rx_d[k] = dfx[RW] ? src_rx[k] : dfx[RW-1:0];
      ry_d[k] = dfy[RW] ? src_ry[k] : dfy[RW-1:0];
      qx_d[k] = {src_qx[k][QB-2:0], ~dfx[RW]};
      qy_d[k] = {src_qy[k][QB-2:0], ~dfy[RW]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= src_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < QB; k++) begin
        rx_q[k] <= rx_d[k];
        ry_q[k] <= ry_d[k];
        qx_q[k] <= qx_d[k];
        qy_q[k] <= qy_d[k];
        d_q[k]  <= src_d[k];
        s_q[k]  <= src_s[k];
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign quo_x_o = qx_q[QB-1];
  assign quo_y_o = qy_q[QB-1];
  assign side_o  = s_q[QB-1];

endmodule

`default_nettype wire

[tb/tb_triangle_circumcircle_test_unit.sv]
`timescale 1ns / 100ps

module tb_triangle_circumcircle_test_unit;
  import tcct_pkg::*;

  // One input word: the three vertices and the query point, raw 16-bit values.
  typedef struct packed {
    logic [15:0] ax, ay, bx, by, cx, cy, qx, qy;
  } tri_word_t;

  localparam logic signed [127:0] CENTER_MAX = (128'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam logic signed [127:0] CENTER_MIN = -(128'sd1 <<< (OUT_BITS - 1));
  // The pipeline is 50 stages deep, so this covers anything still in flight.
  localparam int unsigned DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  tri_word_t in_word = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic signed [OUT_BITS-1:0] center_x, center_y;
  logic                       inside_res, degenerate, is_vertex, center_saturated;

  // Expected circle results, oldest first.
  res_t circle_expected[$];
  int unsigned fail_count = 0;
  // When set, the sender inserts no gaps and the receiver never stalls.
  bit no_idle = 1'b0;
  // Cycles left in a long receiver stall.
  int unsigned stall_left = 0;

  triangle_circumcircle_test_unit uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .vertex_a_x_i       (in_word.ax),
    .vertex_a_y_i       (in_word.ay),
    .vertex_b_x_i       (in_word.bx),
    .vertex_b_y_i       (in_word.by),
    .vertex_c_x_i       (in_word.cx),
    .vertex_c_y_i       (in_word.cy),
    .query_x_i          (in_word.qx),
    .query_y_i          (in_word.qy),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .center_x_o         (center_x),
    .center_y_o         (center_y),
    .inside_res_o       (inside_res),
    .degenerate_o       (degenerate),
    .is_vertex_o        (is_vertex),
    .center_saturated_o (center_saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Truncated quotient (num * 2^8) / den, clipped to the signed 40-bit range.
  // The top bit of the return value tells whether clipping happened.
  function automatic logic [OUT_BITS:0] center_quotient(logic signed [127:0] num,
                                                        logic signed [127:0] den);
    logic signed [127:0] quo;
    begin
      // Signed division in SystemVerilog already truncates toward zero.
      quo = (num <<< FRAC_BITS_DEF) / den;
      if (quo > CENTER_MAX) return {1'b1, CENTER_MAX[OUT_BITS-1:0]};
      if (quo < CENTER_MIN) return {1'b1, CENTER_MIN[OUT_BITS-1:0]};
      return {1'b0, quo[OUT_BITS-1:0]};
    end
  endfunction

  // Works out the circumcenter and the point-in-circle decision exactly, with
  // 128-bit signed integers that are wide enough for every product involved.
  function automatic res_t predict_circle(tri_word_t w);
    logic signed [127:0] ax, ay, bx, by, cx, cy, qx, qy;
    logic signed [127:0] a1, b1, a2, b2, c1, c2, det, nx, ny;
    logic signed [127:0] adx, ady, bdx, bdy, cdx, cdy, al, bl, cl, inc;
    logic [OUT_BITS:0] qx_res, qy_res;
    res_t r;
    begin
      ax = $signed(w.ax); ay = $signed(w.ay);
      bx = $signed(w.bx); by = $signed(w.by);
      cx = $signed(w.cx); cy = $signed(w.cy);
      qx = $signed(w.qx); qy = $signed(w.qy);
      a1 = 2 * (ax - bx); b1 = 2 * (ay - by);
      a2 = 2 * (ax - cx); b2 = 2 * (ay - cy);
      c1 = ax * ax - bx * bx + ay * ay - by * by;
      c2 = ax * ax - cx * cx + ay * ay - cy * cy;
      det = a1 * b2 - a2 * b1;
      r = '0;
      r.deg = (det == 0);
      r.is_vtx = (w.qx == w.ax && w.qy == w.ay) || (w.qx == w.bx && w.qy == w.by) ||
                 (w.qx == w.cx && w.qy == w.cy);
      if (det != 0) begin
        nx = c1 * b2 - c2 * b1;
        ny = a1 * c2 - a2 * c1;
        qx_res = center_quotient(nx, det);
        qy_res = center_quotient(ny, det);
        r.cx = qx_res[OUT_BITS-1:0];
        r.cy = qy_res[OUT_BITS-1:0];
        r.sat = qx_res[OUT_BITS] | qy_res[OUT_BITS];
        adx = ax - qx; ady = ay - qy;
        bdx = bx - qx; bdy = by - qy;
        cdx = cx - qx; cdy = cy - qy;
        al = adx * adx + ady * ady;
        bl = bdx * bdx + bdy * bdy;
        cl = cdx * cdx + cdy * cdy;
        inc = adx * (bdy * cl - cdy * bl) - ady * (bdx * cl - cdx * bl) +
              al * (bdx * cdy - cdx * bdy);
        // The determinant carries the orientation; a point on the circle counts.
        r.in_circle = (det > 0) ? (inc >= 0) : (inc <= 0);
      end
      return r;
    end
  endfunction

  // Sender gap: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    begin
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
    end
  endfunction

  // Drives one word, holds it until the block takes it, and records the
  // expected result at the edge of acceptance.
  task automatic send_word(tri_word_t w);
    int unsigned gap;
    begin
      in_valid <= 1'b1;
      in_word  <= w;
      do @(posedge clk); while (in_stall);
      circle_expected.push_back(predict_circle(w));
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    begin
      while (circle_expected.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] small_coord();
    return 16'($signed($urandom_range(0, 16)) - 8);
  endfunction

  function automatic tri_word_t make_word(int ax, int ay, int bx, int by,
                                          int cx, int cy, int qx, int qy);
    return {16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(cx), 16'(cy), 16'(qx), 16'(qy)};
  endfunction

  // A third vertex close to the line through the first two, so the
  // circumcircle is huge and the center may run out of range.
  function automatic tri_word_t near_line_word();
    tri_word_t w;
    int ax, ay, bx, by, t;
    begin
      w = tri_word_t'({$urandom, $urandom, $urandom, $urandom});
      ax = $signed(w.ax); ay = $signed(w.ay);
      bx = $signed(w.bx); by = $signed(w.by);
      t = $urandom_range(0, 8);
      w.cx = 16'(ax + (bx - ax) * t / 8 + $signed($urandom_range(0, 2)) - 1);
      w.cy = 16'(ay + (by - ay) * t / 8 + $signed($urandom_range(0, 2)) - 1);
      return w;
    end
  endfunction

  // Corners of the coordinate range, all equal and mixed.
  task automatic test_extremes();
    begin
      send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_word(make_word(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
      send_word(make_word(32767, 32767, -32768, 32767, 32767, -32768, 0, 0));
      send_word(make_word(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
      send_word(make_word(0, 0, 1, 0, 0, 1, -32768, 32767));
    end
  endtask

  // Collinear and coincident vertices give a degenerate triangle.
  task automatic test_degenerate();
    begin
      send_word(make_word(0, 0, 1, 1, 2, 2, 0, 0));
      send_word(make_word(5, 5, 5, 5, 9, -3, 1, 1));
      send_word(make_word(-100, 7, 300, 7, 12, 7, 12, 8));
      send_word(make_word(-32768, -32768, 0, 0, 32767, 32767, 3, 3));
    end
  endtask

  // The query equals each vertex in turn.
  task automatic test_vertex_query();
    begin
      send_word(make_word(3, 4, -7, 2, 10, -9, 3, 4));
      send_word(make_word(3, 4, -7, 2, 10, -9, -7, 2));
      send_word(make_word(3, 4, -7, 2, 10, -9, 10, -9));
    end
  endtask

  // Points on the circle count as inside; one point just outside and one inside are sent too.
  task automatic test_on_circle();
    begin
      send_word(make_word(0, 0, 2, 0, 0, 2, 2, 2));
      send_word(make_word(0, 0, 0, 2, 2, 0, 2, 2));
      send_word(make_word(5, 0, 0, 5, -5, 0, 3, -4));
      send_word(make_word(5, 0, 0, 5, -5, 0, 4, -4));
      send_word(make_word(5, 0, 0, 5, -5, 0, 1, 1));
    end
  endtask

  // Nearly collinear triangles with long sides push the center out of range.
  task automatic test_saturation();
    begin
      send_word(make_word(-32768, -32767, 32767, 32766, 0, 0, 0, 1));
      send_word(make_word(32767, 32766, -32768, -32767, 0, 0, 100, -100));
      send_word(make_word(-32768, 0, 32767, 1, 0, 0, 0, 0));
      send_word(make_word(-32768, 1, 32767, 0, 1, 0, 5, 5));
    end
  endtask

  // Random words of several kinds; small coordinates hit degenerate cases,
  // shared vertices and points on the circle often.
  task automatic test_random(int unsigned count);
    tri_word_t w;
    int unsigned kind;
    begin
      repeat (count) begin
        kind = $urandom_range(0, 99);
        w = tri_word_t'({$urandom, $urandom, $urandom, $urandom});
        if (kind < 30) begin
          w = w;
        end else if (kind < 55) begin
          w = {small_coord(), small_coord(), small_coord(), small_coord(),
               small_coord(), small_coord(), small_coord(), small_coord()};
        end else if (kind < 75) begin
          w = near_line_word();
        end else if (kind < 90) begin
          case ($urandom_range(0, 2))
            0: begin w.qx = w.ax; w.qy = w.ay; end
            1: begin w.qx = w.bx; w.qy = w.by; end
            default: begin w.qx = w.cx; w.qy = w.cy; end
          endcase
        end else begin
          // The query shares one coordinate with a vertex but not the other.
          w.qx = w.bx;
        end
        send_word(w);
      end
    end
  endtask

  // The sender holds off until the pipeline has fully drained, then resumes
  // at full rate with no receiver stalls.
  task automatic test_drain_pause();
    begin
      test_random(40);
      in_valid <= 1'b0;
      wait_drained();
      no_idle = 1'b1;
      test_random(60);
      no_idle = 1'b0;
    end
  endtask

  // Receiver stall pattern: runs of ready and stalled cycles, mostly short,
  // with a long stall now and then.
  always @(posedge clk) begin
    if (no_idle) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 199) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(10, 40);
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= ($urandom_range(0, 99) < 8) ? 1'b1 : ~out_stall;
    end
  end

  // Compares each accepted result word, field by field, with the oldest one
  // still expected.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (circle_expected.size() == 0) begin
        $display("%0t: unexpected result word cx=%0d cy=%0d", $time, center_x, center_y);
        fail_count++;
      end else begin
        want = circle_expected.pop_front();
        if (center_x !== want.cx) begin
          $display("%0t: center_x expected %0d actual %0d",
                   $time, $signed(want.cx), center_x);
          fail_count++;
        end
        if (center_y !== want.cy) begin
          $display("%0t: center_y expected %0d actual %0d",
                   $time, $signed(want.cy), center_y);
          fail_count++;
        end
        if (inside_res !== want.in_circle) begin
          $display("%0t: inside_res expected %0b actual %0b", $time, want.in_circle, inside_res);
          fail_count++;
        end
        if (degenerate !== want.deg) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.deg, degenerate);
          fail_count++;
        end
        if (is_vertex !== want.is_vtx) begin
          $display("%0t: is_vertex expected %0b actual %0b", $time, want.is_vtx, is_vertex);
          fail_count++;
        end
        if (center_saturated !== want.sat) begin
          $display("%0t: center_saturated expected %0b actual %0b",
                   $time, want.sat, center_saturated);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_degenerate();
    test_vertex_query();
    test_on_circle();
    test_saturation();
    test_drain_pause();
    test_random(1350);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (circle_expected.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("** triangle_circumcircle_test_unit: PASSED **");
    end else begin
      $display("** triangle_circumcircle_test_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("** triangle_circumcircle_test_unit: FAILED **");
    $finish;
  end

endmodule
